/* rtl/sudpw_pkg.sv */
package sudpw_pkg;

    localparam int MAX_PAYLOAD_DEF = 1024;
    localparam int LEN_W           = 11;
    localparam int REM_W           = 12;
    localparam int GUID_BYTES      = 16;
    localparam int GUID_IDX_W      = $clog2(GUID_BYTES);
    localparam int STEP_W          = 4;

    localparam logic [LEN_W-1:0] LEN_MAX   = '1;
    localparam logic [REM_W-1:0] SIZE_STEP = 12'd255;

    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [7:0] BYTE_ONE     = 8'h01;
    localparam logic [7:0] BYTE_FF      = 8'hFF;
    localparam logic [7:0] BYTE_TRAILER = 8'h80;
    localparam logic [7:0] NAL_H264     = 8'h06;
    localparam logic [7:0] NAL_TYPE_SEI = 8'd39;
    localparam logic [7:0] NAL_H265     = {NAL_TYPE_SEI[6:0], 1'b0};
    localparam logic [7:0] PT_USER_DATA = 8'h05;

    // Program addresses that the sequencer jumps to by name.
    localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_HDR   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_SC1   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SC2   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SC3   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_NAL0  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_NAL1  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_PT    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_SIZE  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_GUID  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_ITEM  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_TRAIL = 4'd11;

    typedef enum logic [2:0] {
        SRC_CONST,
        SRC_NAL,
        SRC_SIZE,
        SRC_GUID,
        SRC_ITEM,
        SRC_INPUT,
        SRC_TRAILER
    } src_sel_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_ALWAYS,
        EM_CARRY,
        EM_LAST,
        EM_DISPATCH
    } emit_cond_t;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_IF_H264,
        J_WHILE_SIZE,
        J_WHILE_GUID,
        J_DISPATCH
    } jump_cond_t;

    typedef struct packed {
        src_sel_t          src;
        emit_cond_t        emit;
        jump_cond_t        jump;
        logic [STEP_W-1:0] target;
        logic [7:0]        konst;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic in_first;
        logic in_last;
        logic in_carries;
        logic in_packet;
        logic carries_reg;
        logic last_reg;
        logic slot_free;
        logic codec_h265;
        logic size_ge;
        logic guid_done;
    } seq_status_t;

    typedef struct packed {
        src_sel_t   src;
        logic [7:0] konst;
        logic       emit;
        logic       advance;
        logic       accept;
        logic       ready;
    } seq_ctrl_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '{src: SRC_INPUT, emit: EM_DISPATCH, jump: J_DISPATCH,
              target: STEP_IDLE, konst: BYTE_ZERO};
        unique case (step)
            STEP_IDLE: ;
            STEP_HDR, STEP_SC1, STEP_SC2:
                w = '{SRC_CONST, EM_ALWAYS, J_NEXT, STEP_IDLE, BYTE_ZERO};
            STEP_SC3:
                w = '{SRC_CONST, EM_ALWAYS, J_NEXT, STEP_IDLE, BYTE_ONE};
            STEP_NAL0:
                w = '{SRC_NAL, EM_ALWAYS, J_IF_H264, STEP_PT, BYTE_ZERO};
            STEP_NAL1:
                w = '{SRC_CONST, EM_ALWAYS, J_NEXT, STEP_IDLE, BYTE_ONE};
            STEP_PT:
                w = '{SRC_CONST, EM_ALWAYS, J_NEXT, STEP_IDLE, PT_USER_DATA};
            STEP_SIZE:
                w = '{SRC_SIZE, EM_ALWAYS, J_WHILE_SIZE, STEP_IDLE, BYTE_ZERO};
            STEP_GUID:
                w = '{SRC_GUID, EM_ALWAYS, J_WHILE_GUID, STEP_IDLE, BYTE_ZERO};
            STEP_ITEM:
                w = '{SRC_ITEM, EM_CARRY, J_NEXT, STEP_IDLE, BYTE_ZERO};
            STEP_TRAIL:
                w = '{SRC_TRAILER, EM_LAST, J_GOTO, STEP_IDLE, BYTE_TRAILER};
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] guid_byte(input logic [GUID_IDX_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (idx)
            4'd0:  b = 8'h54;
            4'd1:  b = 8'h80;
            4'd2:  b = 8'h83;
            4'd3:  b = 8'h97;
            4'd4:  b = 8'hf0;
            4'd5:  b = 8'h23;
            4'd6:  b = 8'h47;
            4'd7:  b = 8'h4b;
            4'd8:  b = 8'hb7;
            4'd9:  b = 8'hf7;
            4'd10: b = 8'h4f;
            4'd11: b = 8'h32;
            4'd12: b = 8'hb5;
            4'd13: b = 8'h4e;
            4'd14: b = 8'h06;
            4'd15: b = 8'hac;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* rtl/sudpw_ifs.sv */
interface sudpw_in_if import sudpw_pkg::*;;
    logic             valid;
    logic             ready;
    logic [7:0]       content_byte;
    logic             carries_byte;
    logic             first_of_packet;
    logic             last_of_packet;
    logic [LEN_W-1:0] payload_length;

    modport source (
        output valid, content_byte, carries_byte, first_of_packet,
               last_of_packet, payload_length,
        input  ready
    );
    modport sink (
        input  valid, content_byte, carries_byte, first_of_packet,
               last_of_packet, payload_length,
        output ready
    );
endinterface

interface sudpw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_unit;
    logic       length_mismatch;

    modport source (
        output valid, out_byte, end_of_unit, length_mismatch,
        input  ready
    );
    modport sink (
        input  valid, out_byte, end_of_unit, length_mismatch,
        output ready
    );
endinterface

/* rtl/sudpw_seq.sv */
module sudpw_seq import sudpw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  seq_status_t status,
    output seq_ctrl_t   ctrl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_t            cw;
    logic              emit_want;
    logic              dispatch;
    logic              accept;

    assign cw       = ucode_rom(step_reg);
    assign dispatch = (cw.jump == J_DISPATCH);
    assign accept   = dispatch && status.in_valid && status.slot_free;

    // Output decode of the current control word.
    always_comb
    begin
        emit_want = 1'b0;
        unique case (cw.emit)
            EM_NONE:     emit_want = 1'b0;
            EM_ALWAYS:   emit_want = 1'b1;
            EM_CARRY:    emit_want = status.carries_reg;
            EM_LAST:     emit_want = status.last_reg;
            EM_DISPATCH: emit_want = !status.in_first && status.in_packet &&
                                     status.in_carries;
            default:     emit_want = 1'b0;
        endcase

        ctrl.src    = cw.src;
        ctrl.konst  = cw.konst;
        ctrl.ready  = dispatch && status.slot_free;
        ctrl.accept = accept;
        if (dispatch)
        begin
            ctrl.emit    = accept && emit_want;
            ctrl.advance = 1'b1;
        end
        else
        begin
            ctrl.emit    = emit_want && status.slot_free;
            ctrl.advance = !emit_want || status.slot_free;
        end
    end

    // Next step: a step that must emit holds until the output register can take it.
    always_comb
    begin
        step_next = step_reg;
        if (ctrl.advance)
        begin
            unique case (cw.jump)
                J_NEXT:       step_next = step_reg + 1'b1;
                J_GOTO:       step_next = cw.target;
                J_IF_H264:    step_next = status.codec_h265 ? step_reg + 1'b1 : cw.target;
                J_WHILE_SIZE: step_next = status.size_ge ? step_reg : step_reg + 1'b1;
                J_WHILE_GUID: step_next = status.guid_done ? step_reg + 1'b1 : step_reg;
                J_DISPATCH:
                begin
                    if (accept && status.in_first)
                        step_next = STEP_HDR;
                    else if (accept && status.in_packet && status.in_last)
                        step_next = STEP_TRAIL;
                    else
                        step_next = STEP_IDLE;
                end
                default:      step_next = STEP_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_IDLE;
        else
            step_reg <= step_next;
    end

    a_first_starts_header: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.in_first) |=> (step_reg == STEP_HDR))
        else $error("first transaction did not start the header program");

    a_step_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_TRAIL)
        else $error("step counter left the program");

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != STEP_IDLE) |-> !ctrl.ready)
        else $error("input taken outside the idle step");

    a_h264_skips_nal1: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_NAL0 && ctrl.advance && !status.codec_h265)
        |=> (step_reg == STEP_PT))
        else $error("H.264 header took the second NAL header byte");

endmodule

/* rtl/sudpw_dp.sv */
module sudpw_dp import sudpw_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    sudpw_in_if.sink          in_ch,
    sudpw_out_if.source       out_ch,
    input  seq_ctrl_t         ctrl,
    output seq_status_t       status
);

    localparam logic [LEN_W-1:0] LEN_CAP =
        (MAX_PAYLOAD > int'(LEN_MAX)) ? LEN_MAX : LEN_W'(MAX_PAYLOAD);

    logic                  codec_mode_reg;
    logic [LEN_W-1:0]      declared_reg;
    logic [LEN_W-1:0]      count_reg;
    logic                  in_packet_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [GUID_IDX_W-1:0] guid_idx_reg;
    logic [7:0]            content_reg;
    logic                  carries_reg;
    logic                  last_reg;
    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;
    logic                  out_eou_reg;
    logic                  out_mis_reg;

    logic [LEN_W-1:0]      len_sat;
    logic                  size_ge;
    logic [7:0]            byte_next;
    logic                  eou_next;
    logic                  count_inc;

    assign len_sat   = (in_ch.payload_length > LEN_CAP) ? LEN_CAP : in_ch.payload_length;
    assign size_ge   = (rem_reg >= SIZE_STEP);
    assign count_inc = ctrl.emit && (ctrl.src == SRC_INPUT || ctrl.src == SRC_ITEM);

    assign in_ch.ready = ctrl.ready;

    assign status.in_valid    = in_ch.valid;
    assign status.in_first    = in_ch.first_of_packet;
    assign status.in_last     = in_ch.last_of_packet;
    assign status.in_carries  = in_ch.carries_byte;
    assign status.in_packet   = in_packet_reg;
    assign status.carries_reg = carries_reg;
    assign status.last_reg    = last_reg;
    assign status.slot_free   = !out_valid_reg || out_ch.ready;
    assign status.codec_h265  = codec_mode_reg;
    assign status.size_ge     = size_ge;
    assign status.guid_done   = (guid_idx_reg == GUID_IDX_W'(GUID_BYTES - 1));

    always_comb
    begin
        eou_next = 1'b0;
        case (ctrl.src)
            SRC_CONST:   byte_next = ctrl.konst;
            SRC_NAL:     byte_next = codec_mode_reg ? NAL_H265 : NAL_H264;
            SRC_SIZE:    byte_next = size_ge ? BYTE_FF : rem_reg[7:0];
            SRC_GUID:    byte_next = guid_byte(guid_idx_reg);
            SRC_ITEM:    byte_next = content_reg;
            SRC_INPUT:   byte_next = in_ch.content_byte;
            SRC_TRAILER:
            begin
                byte_next = BYTE_TRAILER;
                eou_next  = 1'b1;
            end
            default:     byte_next = BYTE_ZERO;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_mode_reg <= 1'b0;
            declared_reg   <= '0;
            count_reg      <= '0;
            in_packet_reg  <= 1'b0;
            rem_reg        <= '0;
            guid_idx_reg   <= '0;
            carries_reg    <= 1'b0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                codec_mode_reg <= cfg_wdata;

            if (ctrl.accept)
            begin
                carries_reg <= in_ch.carries_byte;
                last_reg    <= in_ch.last_of_packet;
                if (in_ch.first_of_packet)
                begin
                    declared_reg  <= len_sat;
                    rem_reg       <= {1'b0, len_sat} + REM_W'(GUID_BYTES);
                    count_reg     <= '0;
                    in_packet_reg <= 1'b1;
                    guid_idx_reg  <= '0;
                end
            end

            if (count_inc && count_reg != LEN_MAX)
                count_reg <= count_reg + 1'b1;

            if (ctrl.advance && ctrl.src == SRC_SIZE && size_ge)
                rem_reg <= rem_reg - SIZE_STEP;

            if (ctrl.advance && ctrl.src == SRC_GUID)
                guid_idx_reg <= guid_idx_reg + 1'b1;

            if (ctrl.emit && ctrl.src == SRC_TRAILER)
                in_packet_reg <= 1'b0;

            if (ctrl.emit)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
            content_reg <= in_ch.content_byte;
        if (ctrl.emit)
        begin
            out_byte_reg <= byte_next;
            out_eou_reg  <= eou_next;
            out_mis_reg  <= eou_next && (count_reg != declared_reg);
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.out_byte        = out_byte_reg;
    assign out_ch.end_of_unit     = out_eou_reg;
    assign out_ch.length_mismatch = out_mis_reg;

    a_trailer_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.emit && ctrl.src == SRC_TRAILER) |=> !in_packet_reg)
        else $error("trailer left the packet open");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= ({1'b0, LEN_CAP} + REM_W'(GUID_BYTES)))
        else $error("size remainder out of range");

    a_declared_bound: assert property (@(posedge clk) disable iff (!rst_n)
        declared_reg <= LEN_CAP)
        else $error("declared length above the cap");

endmodule

/* rtl/sei_user_data_packet_writer_unit.sv */
// A first transaction moves the sequencer to the header step, which registers the first
// output byte; the header emits 23 to 28 bytes with the default cap. Reset is immediate.
// Input stays blocked through the header plus one step for the content byte and one for
// the trailer; every emitting step holds while the output register is full.
// Each later transaction is taken in the idle step; a content byte that it carries enters
// the output register in the same cycle; one ending the packet adds the 0x80 trailer step.
module sei_user_data_packet_writer_unit import sudpw_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    sudpw_in_if.sink    in_ch,
    sudpw_out_if.source out_ch
);

    seq_status_t status;
    seq_ctrl_t   ctrl;

    sudpw_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    sudpw_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .ctrl      (ctrl),
        .status    (status)
    );

endmodule
